[sv/swr_pkg.sv]
// Shared constants, register codes and width helpers for the symbol width repacker.
`default_nettype none

package swr_pkg;

  // Symbol and width field sizes
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned WIDTH_W = 4;

  // Accumulator: up to 7 waiting bits plus one 8-bit input symbol
  localparam int unsigned ACC_W = 2 * SYM_W - 1;
  localparam int unsigned CNT_W = 4;

  // Configuration port index width and register codes
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] REG_IN_WIDTH  = 4'd0;
  localparam logic [IDX_W-1:0] REG_OUT_WIDTH = 4'd1;

  // Width limits and reset values
  localparam logic [WIDTH_W-1:0] WIDTH_MIN     = 4'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX     = 4'd8;
  localparam logic [WIDTH_W-1:0] IN_WIDTH_RST  = 4'd8;
  localparam logic [WIDTH_W-1:0] OUT_WIDTH_RST = 4'd1;

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Zero reads as 1, anything above 8 reads as 8
  function automatic width_t clamp_width(input width_t w);
    width_t r;
    if (w < WIDTH_MIN) begin
      r = WIDTH_MIN;
    end else if (w > WIDTH_MAX) begin
      r = WIDTH_MAX;
    end else begin
      r = w;
    end
    return r;
  endfunction

  // Mask of the low w bits, w in 1..8
  function automatic sym_t low_mask(input width_t w);
    logic [SYM_W:0] m;
    m = ({{SYM_W{1'b0}}, 1'b1} << w) - {{SYM_W{1'b0}}, 1'b1};
    return m[SYM_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/symbol_width_repacker_core.sv]
// Symbol width repacker top level: bit gearbox from in_width to out_width symbols.
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall): one word carries in_symbol, whose low
//   in_width bits are taken MSB first, and stream_last, which closes a stream
//   and flushes waiting bits, padded with zeros on the right.
//   Output channel (out_valid / out_stall): one word per output symbol,
//   right-justified in out_width bits. run_end marks the last word caused by
//   an input word, stream_end the final word of a stream.
//   Config channel (cfg_valid / cfg_ready): index 0 = in_width, 1 = out_width,
//   low 4 bits of cfg_wdata. Values 0 act as 1, above 8 act as 8. A write to
//   either register drops any waiting bits. Other indexes are ignored.
// Timing
//   An input goes into the accumulator, then its words are loaded into the
//   output register one word per cycle while out_stall does not hold it; the
//   next input is taken in the cycle its last word is loaded. At worst an
//   input makes 8 words (8-bit in, 1-bit out). Inputs that only top up the
//   accumulator make no word and do not hold the drain unit.
// Reset: synchronous, active low; widths go to 8 in / 1 out, accumulator empties.
// Stall: the output register holds its word while out_stall is high; the drain
//   unit then waits and in_stall stays high until the input's last word is loaded.
module symbol_width_repacker_core (
  input  wire                       clk,
  input  wire                       rst_n,
  // input words
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [swr_pkg::SYM_W-1:0] in_symbol,
  input  wire                       stream_last,
  // output words
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [swr_pkg::SYM_W-1:0] out_symbol,
  output logic                      run_end,
  output logic                      stream_end,
  // configuration writes
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [swr_pkg::IDX_W-1:0] cfg_index,
  input  wire  [swr_pkg::WIDTH_W-1:0] cfg_wdata
);

  // Config registers, kept already clamped
  swr_pkg::width_t iw_r, iw_nxt;
  swr_pkg::width_t ow_r, ow_nxt;

  // Accumulator: bits right-justified, oldest bit at position cnt_r-1
  swr_pkg::acc_t acc_r, acc_nxt;
  swr_pkg::cnt_t cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;   // drain has words left for current input
  logic          last_r, last_nxt;   // current input closes the stream

  // Output register
  logic          out_valid_r, out_valid_nxt;
  swr_pkg::sym_t out_symbol_r, out_symbol_nxt;
  logic          run_end_r, run_end_nxt;
  logic          stream_end_r, stream_end_nxt;

  logic          out_free;
  logic          drain_fire;
  logic          drain_full;    // a whole symbol is waiting
  logic          drain_final;
  swr_pkg::cnt_t rem_cnt;
  swr_pkg::acc_t full_shift;
  swr_pkg::acc_t pad_shift;
  swr_pkg::sym_t drain_sym;
  swr_pkg::cnt_t base_cnt;
  swr_pkg::acc_t cat_acc;
  swr_pkg::cnt_t cat_cnt;
  logic          cat_has_out;
  logic          in_fire;
  logic          cfg_fire;
  logic          cfg_hit;

  assign out_free = !out_valid_r || !out_stall;

  // Drain step: take the top out_width bits, or the zero-padded remainder
  always_comb begin
    drain_full  = (cnt_r >= swr_pkg::cnt_t'(ow_r));
    full_shift  = acc_r >> (cnt_r - swr_pkg::cnt_t'(ow_r));
    pad_shift   = acc_r << (swr_pkg::cnt_t'(ow_r) - cnt_r);
    rem_cnt     = drain_full ? (cnt_r - swr_pkg::cnt_t'(ow_r)) : '0;
    drain_sym   = (drain_full ? full_shift[swr_pkg::SYM_W-1:0]
                              : pad_shift[swr_pkg::SYM_W-1:0])
                  & swr_pkg::low_mask(ow_r);
    drain_final = (rem_cnt < swr_pkg::cnt_t'(ow_r)) && (!last_r || rem_cnt == '0);
    drain_fire  = busy_r && out_free;
  end

  // New input may enter as the last word of the previous one is loaded
  assign in_stall  = busy_r && !(drain_fire && drain_final);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = !busy_r;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == swr_pkg::REG_IN_WIDTH) ||
                     (cfg_index == swr_pkg::REG_OUT_WIDTH);

  // Append the input bits after what is left in the accumulator
  always_comb begin
    base_cnt    = drain_fire ? rem_cnt : cnt_r;
    cat_acc     = (acc_r << iw_r) |
                  swr_pkg::acc_t'(in_symbol & swr_pkg::low_mask(iw_r));
    cat_cnt     = base_cnt + swr_pkg::cnt_t'(iw_r);
    cat_has_out = (cat_cnt >= swr_pkg::cnt_t'(ow_r)) || stream_last;
  end

  always_comb begin
    iw_nxt         = iw_r;
    ow_nxt         = ow_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    busy_nxt       = busy_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_symbol_nxt = out_symbol_r;
    run_end_nxt    = run_end_r;
    stream_end_nxt = stream_end_r;

    if (drain_fire) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = drain_sym;
      run_end_nxt    = drain_final;
      stream_end_nxt = drain_final && last_r;
      cnt_nxt        = rem_cnt;
      busy_nxt       = !drain_final;
    end

    if (in_fire) begin
      acc_nxt  = cat_acc;
      cnt_nxt  = cat_cnt;
      busy_nxt = cat_has_out;
      last_nxt = stream_last;
    end

    if (cfg_fire && cfg_hit) begin
      if (cfg_index == swr_pkg::REG_IN_WIDTH) begin
        iw_nxt = swr_pkg::clamp_width(cfg_wdata);
      end else begin
        ow_nxt = swr_pkg::clamp_width(cfg_wdata);
      end
      acc_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r        <= swr_pkg::IN_WIDTH_RST;
      ow_r        <= swr_pkg::OUT_WIDTH_RST;
      acc_r       <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      iw_r        <= iw_nxt;
      ow_r        <= ow_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register, no reset needed
  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    run_end_r    <= run_end_nxt;
    stream_end_r <= stream_end_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign run_end    = run_end_r;
  assign stream_end = stream_end_r;

  // Between inputs fewer than out_width bits may wait
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r < swr_pkg::cnt_t'(ow_r)))
    else $error("accumulator holds a full symbol while idle");

  // A stream end word always closes its input's run
  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && stream_end_r) |-> run_end_r)
    else $error("stream_end without run_end");

  // A new input overlaps the drain only on its final word
  a_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |-> (drain_fire && drain_final))
    else $error("input accepted while drain has words left");

  // After a final word the drain is free
  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_fire && drain_final && !in_fire) |=> !busy_r)
    else $error("drain still busy after final word");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for symbol_width_repacker_core: bit-exact gearbox predictor.
`timescale 1ns / 100ps

module testbench;

  // Sender and receiver idle odds (percent per cycle) and the long receiver hold-off
  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Cycles with no handshake at all before the run is declared hung.
  // Worst legit quiet spell is the hold-off plus one 8-word drain.
  localparam int unsigned STUCK_LIMIT  = 3000;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expected output word
  typedef struct packed {
    logic [swr_pkg::SYM_W-1:0] sym;
    logic                      run_end;
    logic                      stream_end;
  } out_word_t;

  // Bit gearbox predictor plus the queue of words still owed by the block
  class repack_scoreboard;
    swr_pkg::width_t in_w_reg;
    swr_pkg::width_t out_w_reg;
    swr_pkg::sym_t   acc_bits;
    int unsigned     acc_count;
    out_word_t       owed_words[$];
    int unsigned     errors;

    function new();
      in_w_reg  = swr_pkg::IN_WIDTH_RST;
      out_w_reg = swr_pkg::OUT_WIDTH_RST;
      acc_bits  = '0;
      acc_count = 0;
      errors    = 0;
    endfunction

    // 0 behaves as 1, anything past 8 behaves as 8
    function int unsigned usable_width(swr_pkg::width_t w);
      int unsigned r;
      r = w;
      if (r < 1) r = 1;
      if (r > swr_pkg::SYM_W) r = swr_pkg::SYM_W;
      return r;
    endfunction

    // Register write; unknown indexes are dropped and keep the accumulator
    function void write_reg(logic [swr_pkg::IDX_W-1:0] idx, swr_pkg::width_t data);
      if (idx == swr_pkg::REG_IN_WIDTH) begin
        in_w_reg = data;
      end else if (idx == swr_pkg::REG_OUT_WIDTH) begin
        out_w_reg = data;
      end else begin
        return;
      end
      acc_bits  = '0;
      acc_count = 0;
    endfunction

    // Push the input's bits MSB first, cut full output words, flush on last
    function void take_input(swr_pkg::sym_t sym, logic last);
      int unsigned iw;
      int unsigned ow;
      logic [swr_pkg::SYM_W:0] keep;
      out_word_t batch[$];
      out_word_t w;
      iw   = usable_width(in_w_reg);
      ow   = usable_width(out_w_reg);
      keep = (9'd1 << ow) - 9'd1;
      w    = '0;
      for (int b = int'(iw) - 1; b >= 0; b--) begin
        acc_bits = {acc_bits[swr_pkg::SYM_W-2:0], sym[b]};
        acc_count++;
        if (acc_count >= ow) begin
          w.sym = acc_bits & keep[swr_pkg::SYM_W-1:0];
          batch.push_back(w);
          acc_bits  = '0;
          acc_count = 0;
        end
      end
      // partial word at stream end: zero-pad on the right
      if (last && acc_count > 0) begin
        w.sym = (acc_bits << (ow - acc_count)) & keep[swr_pkg::SYM_W-1:0];
        batch.push_back(w);
        acc_bits  = '0;
        acc_count = 0;
      end
      if (batch.size() > 0) begin
        batch[batch.size()-1].run_end    = 1'b1;
        batch[batch.size()-1].stream_end = last;
      end
      foreach (batch[i]) owed_words.push_back(batch[i]);
    endfunction

    function void check_word(swr_pkg::sym_t sym, logic re, logic se);
      out_word_t want;
      if (owed_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected word: symbol=%02h run_end=%b stream_end=%b",
                   $time, sym, re, se);
        return;
      end
      want = owed_words.pop_front();
      if (sym !== want.sym || re !== want.run_end || se !== want.stream_end) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] word mismatch: expected %02h/%b/%b got %02h/%b/%b",
                   $time, want.sym, want.run_end, want.stream_end, sym, re, se);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  swr_pkg::sym_t                 in_symbol;
  logic                          stream_last;
  logic                          out_valid;
  logic                          out_stall;
  swr_pkg::sym_t                 out_symbol;
  logic                          run_end;
  logic                          stream_end;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [swr_pkg::IDX_W-1:0]     cfg_index;
  swr_pkg::width_t               cfg_wdata;

  repack_scoreboard    sb = new();

  // Shared knobs between stimulus and receiver
  bit                  calm;       // no idling on either side
  bit                  hold_req;   // ask receiver for one long hold-off
  bit                  hold_done;  // receiver has served the hold-off
  int unsigned         stuck_cycles;

  symbol_width_repacker_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_symbol   (in_symbol),
    .stream_last (stream_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_symbol  (out_symbol),
    .run_end     (run_end),
    .stream_end  (stream_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor: all sampling happens at the edge, on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_word(out_symbol, run_end, stream_end);
      if (in_valid && !in_stall) sb.take_input(in_symbol, stream_last);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  // Watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, stuck_cycles);
      $display("** symbol_width_repacker_core: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall, or one long hold-off when asked.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one input word, hold it until taken, then maybe idle with IDLE_PCT odds.
  // valid stays high between back-to-back words (no low/high in one step).
  task automatic send_word(input swr_pkg::sym_t sym, input logic last);
    in_valid    <= 1'b1;
    in_symbol   <= sym;
    stream_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One register write; valid is left high so writes can chain
  task automatic write_reg(input logic [swr_pkg::IDX_W-1:0] idx,
                           input swr_pkg::width_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Wait until every owed word is out, then let the block settle for words that
  // only topped up the accumulator
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Reconfigure while idle; an unknown index is written too when asked
  task automatic set_widths(input swr_pkg::width_t iw, input swr_pkg::width_t ow,
                            input bit widths, input bit junk);
    logic [swr_pkg::IDX_W-1:0] junk_idx;
    int unsigned               junk_pick;
    drain_and_settle();
    junk_pick = $urandom_range(2, 15);
    junk_idx  = junk_pick[swr_pkg::IDX_W-1:0];
    if (widths) begin
      write_reg(swr_pkg::REG_IN_WIDTH, iw);
      write_reg(swr_pkg::REG_OUT_WIDTH, ow);
    end
    if (junk) write_reg(junk_idx, swr_pkg::width_t'($urandom_range(15)));
    cfg_valid <= 1'b0;
  endtask

  // Random streams: random length, random content, some all-0 / all-1 words
  task automatic random_words(input int unsigned count);
    swr_pkg::sym_t sym;
    logic          last;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        sym = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
        sym = swr_pkg::sym_t'($urandom_range(255));
      end
      last = ($urandom_range(99) < 18);
      send_word(sym, last);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_symbol    = '0;
    stream_last  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset widths, 8 in / 1 out: eight words per input, last flushes cleanly
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'hFF, 1'b1);

    // 3 in / 5 out: words straddle inputs, upper input bits ignored,
    // padded flush at last; an unknown index goes by without effect
    set_widths(4'd3, 4'd5, 1'b1, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h02, 1'b0);
    send_word(8'hFD, 1'b0);
    send_word(8'h05, 1'b1);

    // 4 in / 2 out: last with nothing left to pad still marks stream end
    set_widths(4'd4, 4'd2, 1'b1, 1'b0);
    send_word(8'hF6, 1'b1);
    send_word(8'h39, 1'b0);
    send_word(8'h0C, 1'b1);

    // Out-of-range widths: 0 reads as 1 bit in, 15 as 8 bits out
    set_widths(4'd0, 4'd15, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h81, 1'b1);

    // 15 reads as 8 in, 8 out: one word per input
    set_widths(4'd15, 4'd8, 1'b1, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b1);

    // Random part. Narrowest in / widest out first
    set_widths(4'd1, 4'd8, 1'b1, 1'b1);
    random_words(25);

    // Widest in / narrowest out, worst rate, with a long receiver hold-off
    set_widths(4'd8, 4'd1, 1'b1, 1'b0);
    hold_req = 1'b1;
    random_words(25);

    // No idling on either side for a stretch
    set_widths(swr_pkg::width_t'($urandom_range(15)),
               swr_pkg::width_t'($urandom_range(15)), 1'b1, 1'b0);
    calm = 1'b1;
    random_words(25);
    calm = 1'b0;

    set_widths(swr_pkg::width_t'($urandom_range(15)),
               swr_pkg::width_t'($urandom_range(15)), 1'b1, 1'b1);
    random_words(25);

    // Only an unknown-index write: waiting bits must survive it
    set_widths(4'd0, 4'd0, 1'b0, 1'b1);
    random_words(25);

    set_widths(swr_pkg::width_t'($urandom_range(15)),
               swr_pkg::width_t'($urandom_range(15)), 1'b1, 1'b1);
    random_words(25);

    drain_and_settle();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.owed_words.size() == 0) begin
      $display("** symbol_width_repacker_core: PASSED **");
    end else begin
      $display("** symbol_width_repacker_core: FAILED **");
    end
    $finish;
  end

endmodule
